FILE: rtl/brars_pkg.sv
// Shared constants, codes and types for the block range-add / range-sum unit.
// Depends on nothing; brars_ctrl and the top level refer to it by scoped names.
package brars_pkg;

  // Table geometry. BLOCK_LEN is kept a power of two so that block and offset
  // are plain slices of an index and a block multiply is a shift.
  localparam int TABLE_DEPTH = 1024;
  localparam int OFF_W       = 5;
  localparam int BLOCK_LEN   = 1 << OFF_W;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int BLK_W       = IDX_W - OFF_W;
  localparam int NUM_BLOCKS  = TABLE_DEPTH / BLOCK_LEN;

  // Field widths.
  localparam int CNT_W  = 11;
  localparam int DATA_W = 64;
  localparam int ACT_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SUM  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] pend;
  } blk_entry_t;

  localparam int BLK_ENTRY_W = $bits(blk_entry_t);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } elem_req_t;

  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    blk_entry_t       wdata;
    logic             re;
    logic [BLK_W-1:0] raddr;
  } blk_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    logic              status;
  } result_t;

endpackage

FILE: rtl/brars_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port and registered
// read data. No dependencies.
module brars_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/brars_ctrl.sv
// Sequencer and datapath: walks partial blocks through the element memory and
// whole blocks through the block memory, read-modify-write, one step a cycle.
// Depends on brars_pkg.
module brars_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [brars_pkg::ACT_W-1:0]         action_i,
  input  logic [brars_pkg::IDX_W-1:0]         index_lo_i,
  input  logic [brars_pkg::IDX_W-1:0]         index_hi_i,
  input  logic [brars_pkg::DATA_W-1:0]        value_i,
  input  logic [brars_pkg::CNT_W-1:0]         count_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output brars_pkg::result_t                  res_o,
  output brars_pkg::elem_req_t                elem_req_o,
  input  logic [brars_pkg::DATA_W-1:0]        elem_rdata_i,
  output brars_pkg::blk_req_t                 blk_req_o,
  input  logic [brars_pkg::BLK_ENTRY_W-1:0]   blk_rdata_i
);

  localparam int IDX_W  = brars_pkg::IDX_W;
  localparam int BLK_W  = brars_pkg::BLK_W;
  localparam int OFF_W  = brars_pkg::OFF_W;
  localparam int CNT_W  = brars_pkg::CNT_W;
  localparam int DATA_W = brars_pkg::DATA_W;
  localparam int ACT_W  = brars_pkg::ACT_W;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SEG_RD  = 3'd2;
  localparam logic [2:0] ST_SEG_LAT = 3'd3;
  localparam logic [2:0] ST_WALK    = 3'd4;
  localparam logic [2:0] ST_SEG_WB  = 3'd5;
  localparam logic [2:0] ST_MID     = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [ACT_W-1:0]  act_q, act_d;
  logic [DATA_W-1:0] v_q, v_d;
  logic [IDX_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  end_q, end_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic              iss_q, iss_d;
  logic              pv_q, pv_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic              seg2_q, seg2_d;
  logic              mid_q, mid_d;
  logic [BLK_W-1:0]  mptr_q, mptr_d;
  logic [BLK_W-1:0]  mend_q, mend_d;
  logic [BLK_W-1:0]  mpidx_q, mpidx_d;
  logic              miss_q, miss_d;
  logic              mpv_q, mpv_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] delta_q, delta_d;
  logic [DATA_W-1:0] bsum_q, bsum_d;
  logic [DATA_W-1:0] pend_q, pend_d;
  logic              status_q, status_d;

  logic [CNT_W-1:0]      eff_cnt;
  logic                  bad_load;
  logic                  bad_range;
  logic [BLK_W-1:0]      in_bl;
  logic [BLK_W-1:0]      in_bh;
  logic [DATA_W-1:0]     stored;
  brars_pkg::blk_entry_t brd;

  assign brd = brars_pkg::blk_entry_t'(blk_rdata_i);

  // A count beyond the table acts as the table size.
  assign eff_cnt = (count_i > CNT_W'(brars_pkg::TABLE_DEPTH)) ?
                   CNT_W'(brars_pkg::TABLE_DEPTH) : count_i;

  assign bad_load  = {1'b0, index_lo_i} >= eff_cnt;
  assign bad_range = (index_lo_i > index_hi_i) || ({1'b0, index_hi_i} >= eff_cnt);
  assign in_bl     = index_lo_i[IDX_W-1:OFF_W];
  assign in_bh     = index_hi_i[IDX_W-1:OFF_W];

  // Stored value that makes the effective value equal the loaded one.
  assign stored = v_q - pend_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o.total = (act_q == brars_pkg::ACT_SUM) ? acc_q : '0;
  assign res_o.status = status_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    act_d    = act_q;
    v_d      = v_q;
    hi_d     = hi_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    pidx_d   = pidx_q;
    iss_d    = iss_q;
    pv_d     = pv_q;
    blk_d    = blk_q;
    seg2_d   = seg2_q;
    mid_d    = mid_q;
    mptr_d   = mptr_q;
    mend_d   = mend_q;
    mpidx_d  = mpidx_q;
    miss_d   = miss_q;
    mpv_d    = mpv_q;
    acc_d    = acc_q;
    delta_d  = delta_q;
    bsum_d   = bsum_q;
    pend_d   = pend_q;
    status_d = status_q;
    elem_req_o = '0;
    blk_req_o  = '0;

    unique case (state_q)
      ST_CLEAR: begin
        elem_req_o.we    = 1'b1;
        elem_req_o.waddr = clr_q;
        if (32'(clr_q) < brars_pkg::NUM_BLOCKS) begin
          blk_req_o.we    = 1'b1;
          blk_req_o.waddr = clr_q[BLK_W-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(brars_pkg::TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          v_d      = value_i;
          hi_d     = index_hi_i;
          acc_d    = '0;
          status_d = 1'b0;
          ptr_d    = index_lo_i;
          blk_d    = in_bl;
          mptr_d   = in_bl + 1'b1;
          mend_d   = in_bh - 1'b1;
          if (action_i == brars_pkg::ACT_LOAD) begin
            end_d  = index_lo_i;
            seg2_d = 1'b0;
            mid_d  = 1'b0;
            if (bad_load) begin
              status_d = 1'b1;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_SEG_RD;
            end
          end else if (action_i == brars_pkg::ACT_ADD || action_i == brars_pkg::ACT_SUM) begin
            // First walk stops at the end of the low block or at hi.
            end_d  = (in_bl == in_bh) ? index_hi_i : {in_bl, {OFF_W{1'b1}}};
            seg2_d = (in_bl != in_bh);
            mid_d  = ({1'b0, in_bh} > ({1'b0, in_bl} + 1'b1));
            if (bad_range) begin
              status_d = 1'b1;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_SEG_RD;
            end
          end else begin
            status_d = 1'b1;
            state_d  = ST_DONE;
          end
        end
      end

      ST_SEG_RD: begin
        blk_req_o.re    = 1'b1;
        blk_req_o.raddr = blk_q;
        state_d         = ST_SEG_LAT;
      end

      ST_SEG_LAT: begin
        bsum_d           = brd.sum;
        pend_d           = brd.pend;
        delta_d          = '0;
        elem_req_o.re    = 1'b1;
        elem_req_o.raddr = ptr_q;
        pidx_d           = ptr_q;
        pv_d             = 1'b1;
        iss_d            = (ptr_q != end_q);
        ptr_d            = ptr_q + 1'b1;
        state_d          = ST_WALK;
      end

      ST_WALK: begin
        // Issue the next read while the returned element is written back or summed.
        pv_d = iss_q;
        if (iss_q) begin
          elem_req_o.re    = 1'b1;
          elem_req_o.raddr = ptr_q;
          pidx_d           = ptr_q;
          iss_d            = (ptr_q != end_q);
          ptr_d            = ptr_q + 1'b1;
        end
        if (pv_q) begin
          elem_req_o.waddr = pidx_q;
          if (act_q == brars_pkg::ACT_LOAD) begin
            elem_req_o.we    = 1'b1;
            elem_req_o.wdata = stored;
            delta_d          = stored - elem_rdata_i;
          end else if (act_q == brars_pkg::ACT_ADD) begin
            elem_req_o.we    = 1'b1;
            elem_req_o.wdata = elem_rdata_i + v_q;
            delta_d          = delta_q + v_q;
          end else begin
            acc_d = acc_q + elem_rdata_i + pend_q;
          end
          if (!iss_q) begin
            state_d = ST_SEG_WB;
          end
        end
      end

      ST_SEG_WB: begin
        if (act_q != brars_pkg::ACT_SUM) begin
          blk_req_o.we         = 1'b1;
          blk_req_o.waddr      = blk_q;
          blk_req_o.wdata.sum  = bsum_q + delta_q;
          blk_req_o.wdata.pend = pend_q;
        end
        if (seg2_q) begin
          seg2_d  = 1'b0;
          ptr_d   = {hi_q[IDX_W-1:OFF_W], {OFF_W{1'b0}}};
          end_d   = hi_q;
          blk_d   = hi_q[IDX_W-1:OFF_W];
          state_d = ST_SEG_RD;
        end else if (mid_q) begin
          miss_d  = 1'b1;
          mpv_d   = 1'b0;
          state_d = ST_MID;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_MID: begin
        mpv_d = miss_q;
        if (miss_q) begin
          blk_req_o.re    = 1'b1;
          blk_req_o.raddr = mptr_q;
          mpidx_d         = mptr_q;
          miss_d          = (mptr_q != mend_q);
          mptr_d          = mptr_q + 1'b1;
        end
        if (mpv_q) begin
          if (act_q == brars_pkg::ACT_ADD) begin
            blk_req_o.we         = 1'b1;
            blk_req_o.waddr      = mpidx_q;
            blk_req_o.wdata.sum  = brd.sum;
            blk_req_o.wdata.pend = brd.pend + v_q;
          end else begin
            acc_d = acc_q + brd.sum + (brd.pend << OFF_W);
          end
          if (!miss_q) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      iss_q   <= 1'b0;
      pv_q    <= 1'b0;
      seg2_q  <= 1'b0;
      mid_q   <= 1'b0;
      miss_q  <= 1'b0;
      mpv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      iss_q   <= iss_d;
      pv_q    <= pv_d;
      seg2_q  <= seg2_d;
      mid_q   <= mid_d;
      miss_q  <= miss_d;
      mpv_q   <= mpv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    v_q      <= v_d;
    hi_q     <= hi_d;
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    pidx_q   <= pidx_d;
    blk_q    <= blk_d;
    mptr_q   <= mptr_d;
    mend_q   <= mend_d;
    mpidx_q  <= mpidx_d;
    acc_q    <= acc_d;
    delta_q  <= delta_d;
    bsum_q   <= bsum_d;
    pend_q   <= pend_d;
    status_q <= status_d;
  end

endmodule

FILE: rtl/block_range_add_range_sum_unit.sv
// Top level of the block range-add / range-sum unit: count register, result
// register, sequencer and the element and block memories.
// Depends on brars_pkg, brars_ram and brars_ctrl.
//
// A table of 1024 signed 64-bit elements in blocks of 32; each block keeps a
// sum and a pending add in the block memory. One item is in work at a time.
// After reset the unit zeroes its memories with in_ready_o low. A load or a
// range reads the block entry, walks its elements through the element memory
// and, unless it is a sum, writes the entry back; a range across blocks does so
// for the low and the high block, then walks the whole blocks between, at most
// 30, through the block memory. The element memory's single read port returns
// one element per cycle and the block memory one block per cycle.
// The result register frees the sequencer to take the next item while a
// result still waits.
module block_range_add_range_sum_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [9:0]          index_lo_i,
  input  logic [9:0]          index_hi_i,
  input  logic signed [63:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [63:0]  total_o,
  output logic                status_o,
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_wdata_i
);

  logic [brars_pkg::CNT_W-1:0]       count_q;
  logic                              out_valid_q;
  brars_pkg::result_t                out_q;
  logic                              res_valid;
  logic                              res_ready;
  brars_pkg::result_t                res;
  brars_pkg::elem_req_t              elem_req;
  logic [brars_pkg::DATA_W-1:0]      elem_rdata;
  brars_pkg::blk_req_t               blk_req;
  logic [brars_pkg::BLK_ENTRY_W-1:0] blk_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= brars_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Result register: load when empty or when the held result transfers.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_o     = $signed(out_q.total);
  assign status_o    = out_q.status;

  brars_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .index_lo_i   (index_lo_i),
    .index_hi_i   (index_hi_i),
    .value_i      ($unsigned(value_i)),
    .count_i      (count_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .elem_req_o   (elem_req),
    .elem_rdata_i (elem_rdata),
    .blk_req_o    (blk_req),
    .blk_rdata_i  (blk_rdata)
  );

  brars_ram #(
    .DEPTH (brars_pkg::TABLE_DEPTH),
    .WIDTH (brars_pkg::DATA_W)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_req.we),
    .waddr_i (elem_req.waddr),
    .wdata_i (elem_req.wdata),
    .re_i    (elem_req.re),
    .raddr_i (elem_req.raddr),
    .rdata_o (elem_rdata)
  );

  brars_ram #(
    .DEPTH (brars_pkg::NUM_BLOCKS),
    .WIDTH (brars_pkg::BLK_ENTRY_W)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_req.we),
    .waddr_i (blk_req.waddr),
    .wdata_i (blk_req.wdata),
    .re_i    (blk_req.re),
    .raddr_i (blk_req.raddr),
    .rdata_o (blk_rdata)
  );

endmodule

FILE: tb/brars_checker.sv
// Scoreboard for the block range-add / range-sum unit: watches both channels
// and the count register port, predicts each result and compares it.
// Depends on brars_pkg for widths, action codes and the result type.
module brars_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [9:0]  index_lo_i,
  input  logic [9:0]  index_hi_i,
  input  logic [63:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] total_i,
  input  logic        status_i,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import brars_pkg::*;

  logic [DATA_W-1:0] elem_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] blk_sum  [NUM_BLOCKS];
  logic [DATA_W-1:0] blk_pend [NUM_BLOCKS];
  logic [CNT_W-1:0]  elem_count;
  result_t           due_results [$];
  int                misses;
  result_t           got;
  result_t           want;

  // Add v to lo..hi, or return the sum of effective values over lo..hi.
  function automatic logic [DATA_W-1:0] walk_span(int lo, int hi, bit adding,
                                                  logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] acc;
    int blk;
    acc = '0;
    for (int i = lo; i <= hi; i++) begin
      blk = i / BLOCK_LEN;
      if (adding) begin
        elem_mem[i] += v;
        blk_sum[blk] += v;
      end else begin
        acc += elem_mem[i] + blk_pend[blk];
      end
    end
    return acc;
  endfunction

  function automatic result_t run_action(logic [1:0] act, int lo, int hi,
                                         logic [DATA_W-1:0] v);
    result_t r;
    int lim;
    int bl;
    int bh;
    bit adding;
    logic [DATA_W-1:0] stored;
    r = '0;
    lim = (elem_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(elem_count);
    case (act)
      ACT_LOAD: begin
        if (lo >= lim) begin
          r.status = 1'b1;
        end else begin
          // store so that the effective value equals v under the pending add
          bl = lo / BLOCK_LEN;
          stored = v - blk_pend[bl];
          blk_sum[bl] += stored - elem_mem[lo];
          elem_mem[lo] = stored;
        end
      end
      ACT_ADD, ACT_SUM: begin
        adding = (act == ACT_ADD);
        if (lo > hi || hi >= lim) begin
          r.status = 1'b1;
        end else begin
          bl = lo / BLOCK_LEN;
          bh = hi / BLOCK_LEN;
          if (bl == bh) begin
            r.total = walk_span(lo, hi, adding, v);
          end else begin
            r.total = walk_span(lo, bl * BLOCK_LEN + BLOCK_LEN - 1, adding, v);
            r.total += walk_span(bh * BLOCK_LEN, hi, adding, v);
            for (int b = bl + 1; b < bh; b++) begin
              if (adding) blk_pend[b] += v;
              else r.total += blk_sum[b] + blk_pend[b] * DATA_W'(BLOCK_LEN);
            end
          end
          if (adding) r.total = '0;
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, result_t exp_r, result_t act_r);
    if (misses < 10)
      $display("%0t: %s: total exp %h got %h, status exp %0d got %0d",
               $realtime, what, exp_r.total, act_r.total, exp_r.status, act_r.status);
    misses++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) elem_mem[i] = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        blk_sum[b] = '0;
        blk_pend[b] = '0;
      end
      elem_count = COUNT_RESET;
      due_results.delete();
      misses = 0;
      fail_count_o <= 0;
      due_count_o <= 0;
    end else begin
      if (cfg_we_i) elem_count = cfg_wdata_i;
      // retire before predicting, so a new item never matches an older result
      if (out_valid_i && out_ready_i) begin
        got.total = total_i;
        got.status = status_i;
        if (due_results.size() == 0) begin
          flag_mismatch("result with nothing expected", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.total !== want.total || got.status !== want.status)
            flag_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid_i && in_ready_i)
        due_results.push_back(run_action(action_i, index_lo_i, index_hi_i, value_i));
      fail_count_o <= misses;
      due_count_o <= due_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Top of the testbench: clock, reset, stimulus and verdict for the block
// range-add / range-sum unit. Depends on brars_pkg, the unit and brars_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brars_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [9:0]  index_lo;
  logic [9:0]  index_hi;
  logic [63:0] value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] total;
  logic        status;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  int          fail_count;
  int          due_count;
  int          burst_left;
  int          count_plan [8];
  int          items_plan [8];

  block_range_add_range_sum_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .index_lo_i  (index_lo),
    .index_hi_i  (index_hi),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .total_o     (total),
    .status_o    (status),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  brars_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .index_lo_i   (index_lo),
    .index_hi_i   (index_hi),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .total_i      (total),
    .status_i     (status),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_600_000;
    $display("[block_range_add_range_sum_unit] ERROR");
    $finish;
  end

  // Receiver: rotate through stall patterns, and hold off once for a long
  // stretch so the unit backs up into its input.
  initial begin
    int cyc;
    int seen;
    bit held;
    cyc = 0;
    seen = 0;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (!held && seen == 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else begin
        case ((cyc / 64) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      cyc++;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 64'h7FFF_FFFF_FFFF_FFFF;
      1:       return 64'h8000_0000_0000_0000;
      2:       return '1;
      3:       return '0;
      4:       return 64'(signed'($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item and hold it until the transfer; valid stays high after it
  // unless the burst ends with a gap.
  task automatic send_item(logic [1:0] act, logic [9:0] lo, logic [9:0] hi,
                           logic [63:0] v);
    int gap;
    action   <= act;
    index_lo <= lo;
    index_hi <= hi;
    value    <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_count(int n);
    cfg_wdata <= 11'(n);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item(int lim);
    int pick;
    int lo;
    int hi;
    logic [1:0] act;
    pick = $urandom_range(0, 99);
    if (lim == 0 || pick >= 88) begin
      // noise: any action, any indices
      act = 2'($urandom_range(0, 3));
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
    end else if (pick < 24) begin
      act = ACT_LOAD;
      lo = $urandom_range(0, lim - 1);
      hi = $urandom_range(0, 1023);
    end else begin
      act = (pick < 52) ? ACT_ADD : ACT_SUM;
      lo = $urandom_range(0, lim - 1);
      case ($urandom_range(0, 3))
        0: hi = lo + $urandom_range(0, 6);
        1: hi = lo + $urandom_range(BLOCK_LEN, 4 * BLOCK_LEN);
        2: begin
          lo = $urandom_range(0, BLOCK_LEN - 1);
          hi = lim - 1 - $urandom_range(0, BLOCK_LEN - 1);
        end
        default: hi = $urandom_range(lo, lim - 1);
      endcase
      if (hi > lim - 1) hi = lim - 1;
      if (hi < 0) hi = 0;
      if (lo > hi) lo = hi;
    end
    send_item(act, 10'(lo), 10'(hi), rand_word());
  endtask

  initial begin
    int lim;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    action     = ACT_LOAD;
    index_lo   = '0;
    index_hi   = '0;
    value      = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    burst_left = $urandom_range(1, 16);
    count_plan = '{1, 0, 2047, 1025, 37, 100, 0, 1024};
    items_plan = '{60, 40, 300, 250, 200, 250, 250, 300};
    count_plan[6] = $urandom_range(2, 1023);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, count at its reset value
    send_item(ACT_LOAD, 10'd0, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(ACT_LOAD, 10'd1023, 10'd0, 64'h8000_0000_0000_0000);
    send_item(ACT_SUM, 10'd0, 10'd1023, '0);
    send_item(ACT_ADD, 10'd0, 10'd1023, '1);
    send_item(ACT_SUM, 10'd0, 10'd1023, '0);
    send_item(ACT_ADD, 10'd5, 10'd9, 64'd7);
    send_item(ACT_SUM, 10'd3, 10'd40, '0);
    send_item(ACT_ADD, 10'd31, 10'd32, 64'h0123_4567_89AB_CDEF);
    // load into a block that carries a pending add
    send_item(ACT_LOAD, 10'd40, 10'd0, 64'd123);
    send_item(ACT_SUM, 10'd40, 10'd40, '0);
    send_item(ACT_SUM, 10'd10, 10'd5, '0);
    send_item(ACT_ADD, 10'd1023, 10'd0, 64'd1);
    send_item(ACT_UNKNOWN, 10'h3FF, 10'h3FF, '1);
    send_item(ACT_SUM, 10'd0, 10'd0, '1);
    send_item(ACT_SUM, 10'd1023, 10'd1023, '0);
    send_item(ACT_ADD, 10'd0, 10'd1023, 64'h8000_0000_0000_0000);
    send_item(ACT_SUM, 10'd32, 10'd95, '0);
    send_item(ACT_SUM, 10'd0, 10'd1023, '0);

    for (int p = 0; p < 8; p++) begin
      wait_drained(8);
      write_count(count_plan[p]);
      lim = (count_plan[p] > TABLE_DEPTH) ? TABLE_DEPTH : count_plan[p];
      repeat (items_plan[p]) begin
        // now and then, let the unit drain completely
        if ($urandom_range(0, 149) == 0) wait_drained(0);
        random_item(lim);
      end
    end

    wait_drained(0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("[block_range_add_range_sum_unit] OK");
    end else begin
      $display("[block_range_add_range_sum_unit] ERROR");
    end
    $finish;
  end

endmodule
